@@ rtl/dtso_pkg.sv @@
// dtso_pkg: shared types, constants and the month length table for the
// date/time step offset block; no dependencies
package dtso_pkg;

    localparam int DATE_W   = 27;
    localparam int TIME_W   = 18;
    localparam int STEP_W   = 16;
    localparam int TS_W     = 12;
    localparam int PROD_W   = STEP_W + TS_W;
    localparam int SECS_W   = 29;
    localparam int DIV_QW   = 14;
    localparam int DIV_RW   = 17;
    localparam int YEAR_W   = 14;
    localparam int DAYS_W   = 12;

    localparam logic [TS_W-1:0]   TIMESTEP_RESET = 12'd60;
    localparam logic [DIV_RW-1:0] DIVISOR_10000  = 17'd10000;
    localparam logic [DIV_RW-1:0] DIVISOR_100    = 17'd100;
    localparam logic [DIV_RW-1:0] DIVISOR_86400  = 17'd86400;
    localparam logic [DIV_RW-1:0] DIVISOR_3600   = 17'd3600;
    localparam logic [DIV_RW-1:0] DIVISOR_60     = 17'd60;
    localparam logic [YEAR_W-1:0] MAX_YEAR       = 14'd9999;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_MONTH = 2'd1,
        ERR_YEAR  = 2'd2
    } t_err;

    // which constant division the shared divider runs
    typedef enum logic [2:0] {
        DV_YEAR,
        DV_YCENT,
        DV_MONTH,
        DV_HOUR,
        DV_MIN,
        DV_DAYS,
        DV_HH,
        DV_MM
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     capture;
        t_div_sel div_sel;
        logic     sum;
        logic     carry;
        logic     pack;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic carry_done;
    } t_dp_stat;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/dtso_cdiv.sv @@
// dtso_cdiv: divider for the constant divisors of the block, by reciprocal
// multiplication, product then result registered; uses dtso_pkg
module dtso_cdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dtso_pkg::SECS_W-1:0]   i_dividend,
    input  logic [dtso_pkg::DIV_RW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [dtso_pkg::DIV_QW-1:0]   o_quot,
    output logic [dtso_pkg::DIV_RW-1:0]   o_rem
);

    localparam int XW    = dtso_pkg::SECS_W;
    localparam int QW    = dtso_pkg::DIV_QW;
    localparam int RW    = dtso_pkg::DIV_RW;
    localparam int RCP_W = 30;
    localparam int PRD_W = XW + RCP_W;

    // ceil(2^k / d) with k = 29 + ceil(log2 d), exact for any 29 bit dividend
    localparam logic [RCP_W-1:0] RCP_10000 = 30'd879609303;
    localparam logic [RCP_W-1:0] RCP_100   = 30'd687194768;
    localparam logic [RCP_W-1:0] RCP_86400 = 30'd814453058;
    localparam logic [RCP_W-1:0] RCP_3600  = 30'd610839794;
    localparam logic [RCP_W-1:0] RCP_60    = 30'd572662307;
    localparam int SH_10000 = 43;
    localparam int SH_100   = 36;
    localparam int SH_86400 = 46;
    localparam int SH_3600  = 41;
    localparam int SH_60    = 35;

    logic [XW-1:0]    r_x;
    logic [RW-1:0]    r_dv;
    logic [PRD_W-1:0] r_prod;
    logic [QW-1:0]    r_quo;
    logic [RW-1:0]    r_rem;
    logic             r_busy;
    logic             r_done;
    logic [RCP_W-1:0] recip;
    logic [QW-1:0]    quot;
    logic [XW-1:0]    quot_back;
    logic [XW-1:0]    rem_full;

    always_comb begin
        unique case (i_divisor)
            dtso_pkg::DIVISOR_10000: recip = RCP_10000;
            dtso_pkg::DIVISOR_86400: recip = RCP_86400;
            dtso_pkg::DIVISOR_3600:  recip = RCP_3600;
            dtso_pkg::DIVISOR_60:    recip = RCP_60;
            default:                 recip = RCP_100;
        endcase
    end

    always_comb begin
        unique case (r_dv)
            dtso_pkg::DIVISOR_10000: quot = QW'(r_prod >> SH_10000);
            dtso_pkg::DIVISOR_86400: quot = QW'(r_prod >> SH_86400);
            dtso_pkg::DIVISOR_3600:  quot = QW'(r_prod >> SH_3600);
            dtso_pkg::DIVISOR_60:    quot = QW'(r_prod >> SH_60);
            default:                 quot = QW'(r_prod >> SH_100);
        endcase
        quot_back = XW'(quot) * XW'(r_dv);
        rem_full  = r_x - quot_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end

        if (i_start) begin
            r_x    <= i_dividend;
            r_dv   <= i_divisor;
            r_prod <= PRD_W'(i_dividend) * PRD_W'(recip);
        end

        if (r_busy) begin
            r_quo <= quot;
            r_rem <= rem_full[RW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_done && !r_busy)
        else $error("divider did not finish after product");
`endif

endmodule

@@ rtl/dtso_datapath.sv @@
// dtso_datapath: field registers, shared divider, day carry and packing
// of the date/time step offset block; uses dtso_pkg and dtso_cdiv
module dtso_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtso_pkg::t_dp_cmd             i_cmd,
    output dtso_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [dtso_pkg::TS_W-1:0]     i_cfg_wdata,
    input  logic [dtso_pkg::DATE_W-1:0]   i_start_date,
    input  logic [dtso_pkg::TIME_W-1:0]   i_start_time,
    input  logic [dtso_pkg::STEP_W-1:0]   i_step_count,
    output logic                          o_strobe,
    output logic [dtso_pkg::DATE_W-1:0]   o_result_date,
    output logic [dtso_pkg::TIME_W-1:0]   o_result_time,
    output logic [1:0]                    o_error_code
);

    logic [dtso_pkg::TS_W-1:0]   r_ts;
    logic [dtso_pkg::DATE_W-1:0] r_date_in;
    logic [dtso_pkg::TIME_W-1:0] r_time_in;
    logic [dtso_pkg::PROD_W-1:0] r_prod;
    logic [dtso_pkg::SECS_W-1:0] r_secs;
    logic [13:0]                 r_tmp;
    logic [dtso_pkg::YEAR_W-1:0] r_y;
    logic [6:0]                  r_yc_rem;
    logic [1:0]                  r_yc_q2;
    logic [6:0]                  r_m;
    logic [6:0]                  r_d;
    logic [4:0]                  r_h;
    logic [6:0]                  r_mi;
    logic [6:0]                  r_s;
    logic [dtso_pkg::DAYS_W-1:0] r_days;
    logic [dtso_pkg::DIV_RW-1:0] r_sod;
    logic [4:0]                  r_hh;
    logic [5:0]                  r_mm;
    logic [5:0]                  r_ss;
    dtso_pkg::t_err              r_err;
    logic                        r_strobe;
    logic [dtso_pkg::DATE_W-1:0] r_out_date;
    logic [dtso_pkg::TIME_W-1:0] r_out_time;
    dtso_pkg::t_err              r_out_err;

    logic [dtso_pkg::SECS_W-1:0] div_dividend;
    logic [dtso_pkg::DIV_RW-1:0] div_divisor;
    logic                        div_done;
    logic [dtso_pkg::DIV_QW-1:0] div_quot;
    logic [dtso_pkg::DIV_RW-1:0] div_rem;

    logic                        leap;
    logic [4:0]                  mlen;
    logic                        d_ge;
    logic [5:0]                  carry_cost;
    logic                        carry_roll;
    logic                        bad_month;
    dtso_pkg::t_err              fin_err;
    logic [dtso_pkg::DATE_W-1:0] pack_date;
    logic [dtso_pkg::TIME_W-1:0] pack_time;

    always_comb begin
        div_dividend = r_secs;
        div_divisor  = dtso_pkg::DIVISOR_100;
        unique case (i_cmd.div_sel)
            dtso_pkg::DV_YEAR: begin
                div_dividend = {2'b00, r_date_in};
                div_divisor  = dtso_pkg::DIVISOR_10000;
            end
            dtso_pkg::DV_YCENT: begin
                div_dividend = {15'd0, r_y};
                div_divisor  = dtso_pkg::DIVISOR_100;
            end
            dtso_pkg::DV_MONTH: begin
                div_dividend = {15'd0, r_tmp};
                div_divisor  = dtso_pkg::DIVISOR_100;
            end
            dtso_pkg::DV_HOUR: begin
                div_dividend = {11'd0, r_time_in};
                div_divisor  = dtso_pkg::DIVISOR_10000;
            end
            dtso_pkg::DV_MIN: begin
                div_dividend = {15'd0, r_tmp};
                div_divisor  = dtso_pkg::DIVISOR_100;
            end
            dtso_pkg::DV_DAYS: begin
                div_dividend = r_secs;
                div_divisor  = dtso_pkg::DIVISOR_86400;
            end
            dtso_pkg::DV_HH: begin
                div_dividend = {12'd0, r_sod};
                div_divisor  = dtso_pkg::DIVISOR_3600;
            end
            dtso_pkg::DV_MM: begin
                div_dividend = {15'd0, r_tmp};
                div_divisor  = dtso_pkg::DIVISOR_60;
            end
        endcase
    end

    dtso_cdiv u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // day carry: jump to day 1 of the next month, or finish inside this one
    always_comb begin
        leap = (r_y[1:0] == 2'd0 && r_yc_rem != 7'd0) || (r_yc_rem == 7'd0 && r_yc_q2 == 2'd0);
        mlen = dtso_pkg::month_len(r_m[3:0], leap);
        d_ge = r_d >= {2'b00, mlen};
        carry_cost = d_ge ? 6'd1 : ({1'b0, mlen} - {1'b0, r_d[4:0]} + 6'd1);
        carry_roll = r_days >= {6'd0, carry_cost};
        bad_month  = (r_m == 7'd0) || (r_m > 7'd12);
    end

    always_comb begin
        pack_date = dtso_pkg::DATE_W'(r_y) * 27'd10000 + dtso_pkg::DATE_W'(r_m) * 27'd100
                  + dtso_pkg::DATE_W'(r_d);
        pack_time = dtso_pkg::TIME_W'(r_hh) * 18'd10000 + dtso_pkg::TIME_W'(r_mm) * 18'd100
                  + dtso_pkg::TIME_W'(r_ss);
        if (r_err == dtso_pkg::ERR_MONTH) begin
            fin_err = dtso_pkg::ERR_MONTH;
        end else if (r_y > dtso_pkg::MAX_YEAR) begin
            fin_err = dtso_pkg::ERR_YEAR;
        end else begin
            fin_err = dtso_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts     <= dtso_pkg::TIMESTEP_RESET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ts <= i_cfg_wdata;
            end
            r_strobe <= i_cmd.pack;
        end

        if (i_cmd.load) begin
            r_date_in <= i_start_date;
            r_time_in <= i_start_time;
            r_prod    <= dtso_pkg::PROD_W'(i_step_count) * dtso_pkg::PROD_W'(r_ts);
            r_err     <= dtso_pkg::ERR_NONE;
        end

        if (i_cmd.capture) begin
            unique case (i_cmd.div_sel)
                dtso_pkg::DV_YEAR: begin
                    r_y   <= div_quot;
                    r_tmp <= div_rem[13:0];
                end
                dtso_pkg::DV_YCENT: begin
                    r_yc_rem <= div_rem[6:0];
                    r_yc_q2  <= div_quot[1:0];
                end
                dtso_pkg::DV_MONTH: begin
                    r_m <= div_quot[6:0];
                    r_d <= div_rem[6:0];
                end
                dtso_pkg::DV_HOUR: begin
                    r_h   <= div_quot[4:0];
                    r_tmp <= div_rem[13:0];
                end
                dtso_pkg::DV_MIN: begin
                    r_mi <= div_quot[6:0];
                    r_s  <= div_rem[6:0];
                end
                dtso_pkg::DV_DAYS: begin
                    r_days <= div_quot[dtso_pkg::DAYS_W-1:0];
                    r_sod  <= div_rem;
                    if (div_quot != '0 && bad_month) begin
                        r_err <= dtso_pkg::ERR_MONTH;
                    end
                end
                dtso_pkg::DV_HH: begin
                    r_hh  <= div_quot[4:0];
                    r_tmp <= div_rem[13:0];
                end
                dtso_pkg::DV_MM: begin
                    r_mm <= div_quot[5:0];
                    r_ss <= div_rem[5:0];
                end
            endcase
        end

        if (i_cmd.sum) begin
            r_secs <= {1'b0, r_prod} + dtso_pkg::SECS_W'(r_h) * 29'd3600
                    + dtso_pkg::SECS_W'(r_mi) * 29'd60 + dtso_pkg::SECS_W'(r_s);
        end

        if (i_cmd.carry) begin
            if (carry_roll) begin
                r_d    <= 7'd1;
                r_days <= r_days - {6'd0, carry_cost};
                if (r_m == 7'd12) begin
                    r_m <= 7'd1;
                    r_y <= r_y + 14'd1;
                    if (r_yc_rem == 7'd99) begin
                        r_yc_rem <= 7'd0;
                        r_yc_q2  <= r_yc_q2 + 2'd1;
                    end else begin
                        r_yc_rem <= r_yc_rem + 7'd1;
                    end
                end else begin
                    r_m <= r_m + 7'd1;
                end
            end else begin
                r_d    <= r_d + {2'b00, r_days[4:0]};
                r_days <= '0;
            end
        end

        if (i_cmd.pack) begin
            r_out_err  <= fin_err;
            r_out_date <= (fin_err == dtso_pkg::ERR_NONE) ? pack_date : '0;
            r_out_time <= (fin_err == dtso_pkg::ERR_NONE) ? pack_time : '0;
        end
    end

    assign o_stat.div_done   = div_done;
    assign o_stat.carry_done = (r_days == '0) || (r_err != dtso_pkg::ERR_NONE);

    assign o_strobe      = r_strobe;
    assign o_result_date = r_out_date;
    assign o_result_time = r_out_time;
    assign o_error_code  = r_out_err;

`ifndef SYNTHESIS
    a_carry_month_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carry |-> r_m >= 7'd1 && r_m <= 7'd12)
        else $error("day carry with month out of range");
    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_out_err != dtso_pkg::ERR_NONE |-> r_out_date == '0 && r_out_time == '0)
        else $error("error result with nonzero date or time");
`endif

endmodule

@@ rtl/dtso_ctrl.sv @@
// dtso_ctrl: sequencing state machine of the date/time step offset
// block; uses dtso_pkg command and status types
module dtso_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output dtso_pkg::t_dp_cmd  o_cmd,
    input  dtso_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DWAIT,
        S_SUM,
        S_CARRY,
        S_PACK
    } t_state;

    t_state             r_state;
    t_state             n_state;
    dtso_pkg::t_div_sel r_sel;
    dtso_pkg::t_div_sel n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DSTART;
                    n_sel   = dtso_pkg::DV_YEAR;
                end
            end
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DSTART;
                    unique case (r_sel)
                        dtso_pkg::DV_YEAR:  n_sel = dtso_pkg::DV_YCENT;
                        dtso_pkg::DV_YCENT: n_sel = dtso_pkg::DV_MONTH;
                        dtso_pkg::DV_MONTH: n_sel = dtso_pkg::DV_HOUR;
                        dtso_pkg::DV_HOUR:  n_sel = dtso_pkg::DV_MIN;
                        dtso_pkg::DV_MIN:   n_state = S_SUM;
                        dtso_pkg::DV_DAYS:  n_state = S_CARRY;
                        dtso_pkg::DV_HH:    n_sel = dtso_pkg::DV_MM;
                        dtso_pkg::DV_MM:    n_state = S_PACK;
                    endcase
                end
            end
            S_SUM: begin
                n_state = S_DSTART;
                n_sel   = dtso_pkg::DV_DAYS;
            end
            S_CARRY: begin
                if (i_stat.carry_done) begin
                    n_state = S_DSTART;
                    n_sel   = dtso_pkg::DV_HH;
                end
            end
            S_PACK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= dtso_pkg::DV_YEAR;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.div_sel   = r_sel;
        o_cmd.load      = (r_state == S_IDLE) && i_start;
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.capture   = (r_state == S_DWAIT) && i_stat.div_done;
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.carry     = (r_state == S_CARRY) && !i_stat.carry_done;
        o_cmd.pack      = (r_state == S_PACK);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/date_time_step_offset.sv @@
// Adds step_count * timestep_seconds to a packed yyyymmdd date and hhmmss
// time. A request is taken when start is high and busy is low; the
// result appears for exactly one cycle with o_strobe and cannot be held
// off, so it must be captured in that cycle. A request runs to its end
// before the next one is taken: eight constant divisions run in turn on
// the one shared reciprocal-multiply divider (field split of date,
// century of year, time split, days, hours and minutes), with the
// seconds sum after the time split, the day carry after the days
// division (one step per calendar month stepped through and one for a
// last partial month if any, none when no whole day is added), and the
// packing after the minutes division. The timestep register may be
// written at any time the block is not busy.
// Depends on dtso_pkg, dtso_ctrl, dtso_datapath and dtso_cdiv.
module date_time_step_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [dtso_pkg::TS_W-1:0]     i_cfg_wdata,
    input  logic [dtso_pkg::DATE_W-1:0]   i_start_date,
    input  logic [dtso_pkg::TIME_W-1:0]   i_start_time,
    input  logic [dtso_pkg::STEP_W-1:0]   i_step_count,
    output logic                          o_strobe,
    output logic [dtso_pkg::DATE_W-1:0]   o_result_date,
    output logic [dtso_pkg::TIME_W-1:0]   o_result_time,
    output logic [1:0]                    o_error_code
);

    dtso_pkg::t_dp_cmd  dp_cmd;
    dtso_pkg::t_dp_stat dp_stat;

    dtso_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    dtso_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start_date  (i_start_date),
        .i_start_time  (i_start_time),
        .i_step_count  (i_step_count),
        .o_strobe      (o_strobe),
        .o_result_date (o_result_date),
        .o_result_time (o_result_time),
        .o_error_code  (o_error_code)
    );

endmodule
